### hw/rtl/gps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gps_pkg;

    // Width of one signed goal, limit or step field.
    localparam int FIELD_BITS     = 12;
    // Default width of the internal drive registers.
    localparam int DRIVE_BITS_DEF = 12;

    // Phase codes.
    localparam int PHASE_BITS = 3;
    localparam logic [PHASE_BITS-1:0] PH_OPEN      = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_CLOSING   = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_TIGHTEN   = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_HOLDING   = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_RELEASING = 3'd4;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 36;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OPEN_PAIR     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_PAIR     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE_PAIR  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOSING_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIGHTEN_LIMIT = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RAMP_STEPS    = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEADBAND      = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ACT_MAX       = 3'd7;

    localparam int PAIR_BITS     = 24;
    localparam int STEPS_BITS    = 36;
    localparam int DEADBAND_BITS = 15;
    localparam int ACT_MAX_BITS  = 11;
    localparam int SPEED_BITS    = 16;

    // Stream payload widths.
    localparam int IN_DATA_BITS  = 40;
    localparam int OUT_DATA_BITS = 32;

    // One control tick as held in the input register.
    typedef struct packed {
        logic                  grip_request;
        logic [FIELD_BITS-1:0] flexor_pwm;
        logic [FIELD_BITS-1:0] extensor_pwm;
        logic [SPEED_BITS-1:0] extensor_speed;
    } t_item;

    // All configuration registers, as seen by the phase logic.
    typedef struct packed {
        logic [PAIR_BITS-1:0]     open_pair;
        logic [PAIR_BITS-1:0]     hold_pair;
        logic [PAIR_BITS-1:0]     release_pair;
        logic [PAIR_BITS-1:0]     closing_limit;
        logic [PAIR_BITS-1:0]     tighten_limit;
        logic [STEPS_BITS-1:0]    ramp_steps;
        logic [DEADBAND_BITS-1:0] deadband;
        logic [ACT_MAX_BITS-1:0]  act_max;
    } t_cfg;

endpackage

`default_nettype wire

### hw/rtl/gps_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module gps_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    input  wire logic [gps_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [gps_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output gps_pkg::t_cfg                           o_cfg
);
    import gps_pkg::*;

    t_cfg r_cfg;

    // Register file: one write transaction per cycle, all fields reset to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OPEN_PAIR:     r_cfg.open_pair     <= i_cfg_data[PAIR_BITS-1:0];
                CFG_HOLD_PAIR:     r_cfg.hold_pair     <= i_cfg_data[PAIR_BITS-1:0];
                CFG_RELEASE_PAIR:  r_cfg.release_pair  <= i_cfg_data[PAIR_BITS-1:0];
                CFG_CLOSING_LIMIT: r_cfg.closing_limit <= i_cfg_data[PAIR_BITS-1:0];
                CFG_TIGHTEN_LIMIT: r_cfg.tighten_limit <= i_cfg_data[PAIR_BITS-1:0];
                CFG_RAMP_STEPS:    r_cfg.ramp_steps    <= i_cfg_data[STEPS_BITS-1:0];
                CFG_DEADBAND:      r_cfg.deadband      <= i_cfg_data[DEADBAND_BITS-1:0];
                CFG_ACT_MAX:       r_cfg.act_max       <= i_cfg_data[ACT_MAX_BITS-1:0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### hw/rtl/gps_phase_logic.sv
`timescale 1ns / 1ps
`default_nettype none

module gps_phase_logic #(
    parameter int DRIVE_BITS = gps_pkg::DRIVE_BITS_DEF
) (
    input  wire gps_pkg::t_item                    i_item,
    input  wire gps_pkg::t_cfg                     i_cfg,
    input  wire logic [gps_pkg::PHASE_BITS-1:0]    i_phase,
    input  wire logic signed [DRIVE_BITS-1:0]      i_flexor_drive,
    input  wire logic signed [DRIVE_BITS-1:0]      i_extensor_drive,
    output logic [gps_pkg::PHASE_BITS-1:0]         o_phase,
    output logic signed [DRIVE_BITS-1:0]           o_flexor_drive,
    output logic signed [DRIVE_BITS-1:0]           o_extensor_drive
);
    import gps_pkg::*;

    // Extended width: holds any field, any drive and one sum without overflow.
    localparam int EW = ((DRIVE_BITS > FIELD_BITS) ? DRIVE_BITS : FIELD_BITS) + 1;
    localparam int PW = 20;

    localparam logic signed [EW-1:0] DRV_MAX =
        {{(EW-DRIVE_BITS+1){1'b0}}, {(DRIVE_BITS-1){1'b1}}};
    localparam logic signed [EW-1:0] DRV_MIN =
        {{(EW-DRIVE_BITS+1){1'b1}}, {(DRIVE_BITS-1){1'b0}}};

    // Clamp an extended value to the signed drive range.
    function automatic logic signed [DRIVE_BITS-1:0] sat_drive(logic signed [EW-1:0] v);
        logic signed [EW-1:0] c;
        begin
            if (v > DRV_MAX) begin
                c = DRV_MAX;
            end else if (v < DRV_MIN) begin
                c = DRV_MIN;
            end else begin
                c = v;
            end
            sat_drive = c[DRIVE_BITS-1:0];
        end
    endfunction

    logic signed [FIELD_BITS-1:0] fpwm, epwm;
    logic signed [PW-1:0]         fpwm_x100, epwm_x100;
    logic signed [PW-1:0]         cl_f_x99, cl_e_x99, tl_f_x99, tl_e_x99;
    logic signed [EW-1:0]         open_f, open_e, hold_f, hold_e, rel_f, rel_e, cl_e;
    logic signed [EW-1:0]         step_cf, step_tf, step_te;
    logic signed [EW-1:0]         sum_cf, sum_tf, sum_te;
    logic signed [SPEED_BITS:0]   speed_x;
    logic [SPEED_BITS:0]          abs_speed;
    logic signed [FIELD_BITS:0]   epwm_x;
    logic [FIELD_BITS:0]          abs_epwm;
    logic [FIELD_BITS+2:0]        epwm_x4;
    logic [FIELD_BITS:0]          act_max_x3;
    logic                         closing_done, tighten_done, release_done;

    // Threshold products: pwm*100 against limit*99.
    assign fpwm      = $signed(i_item.flexor_pwm);
    assign epwm      = $signed(i_item.extensor_pwm);
    assign fpwm_x100 = PW'(fpwm) * 20'sd100;
    assign epwm_x100 = PW'(epwm) * 20'sd100;
    assign cl_f_x99  = PW'($signed(i_cfg.closing_limit[FIELD_BITS-1:0])) * 20'sd99;
    assign cl_e_x99  = PW'($signed(i_cfg.closing_limit[2*FIELD_BITS-1:FIELD_BITS])) * 20'sd99;
    assign tl_f_x99  = PW'($signed(i_cfg.tighten_limit[FIELD_BITS-1:0])) * 20'sd99;
    assign tl_e_x99  = PW'($signed(i_cfg.tighten_limit[2*FIELD_BITS-1:FIELD_BITS])) * 20'sd99;

    assign closing_done = (fpwm_x100 >= cl_f_x99) && (epwm_x100 <= cl_e_x99);
    assign tighten_done = (fpwm_x100 >= tl_f_x99) && (epwm_x100 >= tl_e_x99);

    // Release ends when the extensor has stopped and pushes above 3/4 scale.
    assign speed_x    = (SPEED_BITS+1)'($signed(i_item.extensor_speed));
    assign abs_speed  = speed_x[SPEED_BITS] ? unsigned'(-speed_x) : unsigned'(speed_x);
    assign epwm_x     = (FIELD_BITS+1)'(epwm);
    assign abs_epwm   = epwm_x[FIELD_BITS] ? unsigned'(-epwm_x) : unsigned'(epwm_x);
    assign epwm_x4    = {abs_epwm, 2'b00};
    assign act_max_x3 = (FIELD_BITS+1)'(i_cfg.act_max) * 13'd3;
    assign release_done = (abs_speed < (SPEED_BITS+1)'(i_cfg.deadband))
                       && (epwm_x4 > (FIELD_BITS+3)'(act_max_x3));

    // Configured goals and steps, sign-extended.
    assign open_f  = EW'($signed(i_cfg.open_pair[FIELD_BITS-1:0]));
    assign open_e  = EW'($signed(i_cfg.open_pair[2*FIELD_BITS-1:FIELD_BITS]));
    assign hold_f  = EW'($signed(i_cfg.hold_pair[FIELD_BITS-1:0]));
    assign hold_e  = EW'($signed(i_cfg.hold_pair[2*FIELD_BITS-1:FIELD_BITS]));
    assign rel_f   = EW'($signed(i_cfg.release_pair[FIELD_BITS-1:0]));
    assign rel_e   = EW'($signed(i_cfg.release_pair[2*FIELD_BITS-1:FIELD_BITS]));
    assign cl_e    = EW'($signed(i_cfg.closing_limit[2*FIELD_BITS-1:FIELD_BITS]));
    assign step_cf = EW'($signed(i_cfg.ramp_steps[FIELD_BITS-1:0]));
    assign step_tf = EW'($signed(i_cfg.ramp_steps[2*FIELD_BITS-1:FIELD_BITS]));
    assign step_te = EW'($signed(i_cfg.ramp_steps[3*FIELD_BITS-1:2*FIELD_BITS]));

    // Ramp sums.
    assign sum_cf = EW'(i_flexor_drive) + step_cf;
    assign sum_tf = EW'(i_flexor_drive) + step_tf;
    assign sum_te = EW'(i_extensor_drive) + step_te;

    // Phase transition and drive update.
    always_comb begin
        o_phase          = i_phase;
        o_flexor_drive   = i_flexor_drive;
        o_extensor_drive = i_extensor_drive;
        case (i_phase)
            PH_OPEN: begin
                if (i_item.grip_request) begin
                    o_phase = PH_CLOSING;
                end
                o_flexor_drive   = sat_drive(open_f);
                o_extensor_drive = sat_drive(open_e);
            end
            PH_CLOSING: begin
                if (closing_done) begin
                    o_phase = PH_TIGHTEN;
                end else begin
                    o_flexor_drive   = sat_drive(sum_cf);
                    o_extensor_drive = sat_drive(cl_e);
                end
            end
            PH_TIGHTEN: begin
                if (tighten_done) begin
                    o_phase = PH_HOLDING;
                end else begin
                    o_flexor_drive   = sat_drive(sum_tf);
                    o_extensor_drive = sat_drive(sum_te);
                end
            end
            PH_HOLDING: begin
                if (!i_item.grip_request) begin
                    o_phase = PH_RELEASING;
                end
                o_flexor_drive   = sat_drive(hold_f);
                o_extensor_drive = sat_drive(hold_e);
            end
            PH_RELEASING: begin
                if (release_done) begin
                    o_phase = PH_OPEN;
                end
                o_flexor_drive   = sat_drive(rel_f);
                o_extensor_drive = sat_drive(rel_e);
            end
            default: begin
                // Unused codes fall back to releasing with drives kept.
                o_phase = PH_RELEASING;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/gripper_pwm_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Gripper PWM sequencer.
// Each transaction on the s_axis channel is one control tick: tdata carries the
// present flexor PWM, extensor PWM and extensor speed, tuser the grip request.
// For every tick the m_axis channel returns one result: the flexor and extensor
// PWM goals and the phase (open, closing, tightening, holding, releasing)
// after the update.
// The cfg channel writes the goal pairs, limits, ramp steps, speed deadband
// and full PWM scale; it is always ready. The user must write it only while no
// tick is in flight; the block itself does not enforce this.
// A tick is taken into an input register; once the result register is free, the
// phase logic updates the state and loads the result register, from which the
// result is offered. One tick per cycle is sustained while the receiver takes
// every result: the state update is a single pass of compares, small constant
// products and one add per motor between the input and result registers.
// When the receiver stalls, the result register holds, then the input register
// fills, and only then does s_axis tready drop.
// Reset empties both registers, sets the phase to releasing, the drives to
// zero and all configuration registers to zero.
module gripper_pwm_sequencer_core #(
    parameter int DRIVE_BITS = gps_pkg::DRIVE_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Tick input.
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [11:0] flexor_pwm, [23:12] extensor_pwm, [39:24] extensor_speed
    input  wire logic [gps_pkg::IN_DATA_BITS-1:0]   i_s_axis_tdata,
    // [0] grip_request
    input  wire logic                               i_s_axis_tuser,
    // Result output.
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [11:0] flexor_goal, [23:12] extensor_goal, [26:24] grip_phase, [31:27] zero
    output logic [gps_pkg::OUT_DATA_BITS-1:0]       o_m_axis_tdata,
    // Configuration writes.
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [gps_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [gps_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import gps_pkg::*;

    localparam int OW = (DRIVE_BITS > FIELD_BITS) ? DRIVE_BITS : FIELD_BITS;

    t_cfg                         w_cfg;
    t_item                        r_item;
    logic                         r_in_valid;
    logic                         r_out_valid;
    logic [OUT_DATA_BITS-1:0]     r_out_data;
    logic [PHASE_BITS-1:0]        r_phase, n_phase;
    logic signed [DRIVE_BITS-1:0] r_flexor_drive, n_flexor_drive;
    logic signed [DRIVE_BITS-1:0] r_extensor_drive, n_extensor_drive;
    logic signed [OW-1:0]         w_flexor_ext, w_extensor_ext;
    logic                         w_advance;

    // Configuration register file.
    assign o_cfg_ready = 1'b1;

    gps_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Handshake: the held tick moves on whenever the result register frees up.
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item.grip_request   <= i_s_axis_tuser;
            r_item.flexor_pwm     <= i_s_axis_tdata[FIELD_BITS-1:0];
            r_item.extensor_pwm   <= i_s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS];
            r_item.extensor_speed <= i_s_axis_tdata[2*FIELD_BITS+SPEED_BITS-1:2*FIELD_BITS];
        end
    end

    // Phase machine and drive update.
    gps_phase_logic #(
        .DRIVE_BITS (DRIVE_BITS)
    ) u_phase_logic (
        .i_item           (r_item),
        .i_cfg            (w_cfg),
        .i_phase          (r_phase),
        .i_flexor_drive   (r_flexor_drive),
        .i_extensor_drive (r_extensor_drive),
        .o_phase          (n_phase),
        .o_flexor_drive   (n_flexor_drive),
        .o_extensor_drive (n_extensor_drive)
    );

    // Sequencer state, committed once per tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_RELEASING;
            r_flexor_drive   <= '0;
            r_extensor_drive <= '0;
        end else if (w_advance) begin
            r_phase          <= n_phase;
            r_flexor_drive   <= n_flexor_drive;
            r_extensor_drive <= n_extensor_drive;
        end
    end

    // Goals carry the low field bits of the drives.
    assign w_flexor_ext   = OW'(n_flexor_drive);
    assign w_extensor_ext = OW'(n_extensor_drive);

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {{(OUT_DATA_BITS-2*FIELD_BITS-PHASE_BITS){1'b0}}, n_phase,
                           w_extensor_ext[FIELD_BITS-1:0], w_flexor_ext[FIELD_BITS-1:0]};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // A committed tick shows its new phase in the result register.
    a_result_phase : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (o_m_axis_tdata[2*FIELD_BITS+PHASE_BITS-1:2*FIELD_BITS] == r_phase))
        else $error("result phase differs from committed state");

    // State moves only when a tick is committed.
    a_state_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !w_advance) |=>
            ($stable(r_phase) && $stable(r_flexor_drive) && $stable(r_extensor_drive)))
        else $error("state changed without a committed tick");

    // A held tick is not overwritten while the result side is blocked.
    a_item_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_item)))
        else $error("pending tick lost");

    // Nothing is offered in the cycle after a reset edge.
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && !r_in_valid))
        else $error("valid result after reset");

    // The state register never holds an unused phase code.
    a_phase_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_RELEASING)
        else $error("phase register out of range");

endmodule

`default_nettype wire
